// ===== hdl/ps2mct_pkg.sv =====
package ps2mct_pkg;

  // Fixed field widths of the byte stream, the registers and the reported position.
  localparam int BYTE_BITS   = 8;
  localparam int SCREEN_BITS = 13;
  localparam int PTR_BITS    = 8;
  localparam int POS_BITS    = 12;
  localparam int DELTA_BITS  = 9;
  localparam int CFG_IDX_BITS = 2;

  // Header byte bit positions.
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;

  // Register reset values.
  localparam logic [SCREEN_BITS-1:0] SCREEN_W_RST = 13'd1024;
  localparam logic [SCREEN_BITS-1:0] SCREEN_H_RST = 13'd768;
  localparam logic [PTR_BITS-1:0]    PTR_W_RST    = 8'd16;
  localparam logic [PTR_BITS-1:0]    PTR_H_RST    = 8'd16;

  // Cursor home position after reset.
  localparam int CURSOR_HOME = 50;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_W = 2'd0,
    REG_SCREEN_H = 2'd1,
    REG_PTR_W    = 2'd2,
    REG_PTR_H    = 2'd3
  } reg_idx_t;

  // Where the framer is within a three byte packet.
  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_DX     = 2'd1,
    POS_DY     = 2'd2
  } pos_t;

  // Configuration values seen by the cursor logic.
  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen_width;
    logic [SCREEN_BITS-1:0] screen_height;
    logic [PTR_BITS-1:0]    pointer_width;
    logic [PTR_BITS-1:0]    pointer_height;
  } cfg_t;

  // What the framer decided for the byte being accepted.
  typedef struct packed {
    logic                         done;
    logic                         dropped;
    logic                         left;
    logic                         right;
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
  } pkt_t;

endpackage

// ===== hdl/ps2mct_regs.sv =====
module ps2mct_regs
  import ps2mct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SCREEN_BITS-1:0]  cfg_data,
  output cfg_t                    cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file with reset defaults; data is cut to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width   <= SCREEN_W_RST;
      cfg.screen_height  <= SCREEN_H_RST;
      cfg.pointer_width  <= PTR_W_RST;
      cfg.pointer_height <= PTR_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SCREEN_W: cfg.screen_width   <= cfg_data;
        REG_SCREEN_H: cfg.screen_height  <= cfg_data;
        REG_PTR_W:    cfg.pointer_width  <= cfg_data[PTR_BITS-1:0];
        REG_PTR_H:    cfg.pointer_height <= cfg_data[PTR_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/ps2mct_framer.sv =====
module ps2mct_framer
  import ps2mct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [BYTE_BITS-1:0] data_byte,
  output pos_t                 pos,
  output pkt_t                 pkt
);

  pos_t                 pos_next;
  logic [BYTE_BITS-1:0] header_byte;
  logic [BYTE_BITS-1:0] delta_x_byte;

  // Next position within the packet. A header without the sync bit is dropped.
  always_comb begin
    unique case (pos)
      POS_HEADER: pos_next = data_byte[HDR_SYNC] ? POS_DX : POS_HEADER;
      POS_DX:     pos_next = POS_DY;
      POS_DY:     pos_next = POS_HEADER;
      default:    pos_next = data_byte[HDR_SYNC] ? POS_DX : POS_HEADER;
    endcase
  end

  // Packet decode for the current byte.
  always_comb begin
    pkt.done    = 1'b0;
    pkt.dropped = 1'b0;
    pkt.left    = header_byte[HDR_LEFT];
    pkt.right   = header_byte[HDR_RIGHT];
    pkt.dx      = {header_byte[HDR_XSIGN], delta_x_byte};
    pkt.dy      = {header_byte[HDR_YSIGN], data_byte};
    unique case (pos)
      POS_HEADER: pkt.dropped = !data_byte[HDR_SYNC];
      POS_DX:     ;
      POS_DY:     pkt.done = 1'b1;
      default:    pkt.dropped = !data_byte[HDR_SYNC];
    endcase
  end

  // Position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HEADER;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Captured header and X delta bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= '0;
      delta_x_byte <= '0;
    end else if (accept) begin
      if (pos == POS_DX) begin
        delta_x_byte <= data_byte;
      end else if (pos != POS_DY && data_byte[HDR_SYNC]) begin
        header_byte <= data_byte;
      end
    end
  end

endmodule

// ===== hdl/ps2mct_cursor.sv =====
module ps2mct_cursor
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  pkt_t                  pkt,
  input  cfg_t                  cfg,
  output logic [COORD_BITS-1:0] col_next,
  output logic [COORD_BITS-1:0] row_next,
  output logic                  left_next,
  output logic                  right_next
);

  // Signed working width that holds a coordinate, a delta and a screen size.
  localparam int CW = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 3;
  localparam logic signed [CW-1:0] COORD_MAX = CW'({COORD_BITS{1'b1}});

  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic                  left_state;
  logic                  right_state;

  logic signed [CW-1:0] sum_x;
  logic signed [CW-1:0] sum_y;
  logic signed [CW-1:0] lim_x_raw;
  logic signed [CW-1:0] lim_y_raw;
  logic signed [CW-1:0] lim_x;
  logic signed [CW-1:0] lim_y;
  logic signed [CW-1:0] new_x;
  logic signed [CW-1:0] new_y;

  // Edge limits, saturated to the coordinate range.
  always_comb begin
    lim_x_raw = $signed(CW'(cfg.screen_width)) - $signed(CW'(cfg.pointer_width));
    lim_y_raw = $signed(CW'(cfg.screen_height)) - $signed(CW'(cfg.pointer_height))
                - CW'(1);
    if (lim_x_raw < 0)              lim_x = '0;
    else if (lim_x_raw > COORD_MAX) lim_x = COORD_MAX;
    else                            lim_x = lim_x_raw;
    if (lim_y_raw < 0)              lim_y = '0;
    else if (lim_y_raw > COORD_MAX) lim_y = COORD_MAX;
    else                            lim_y = lim_y_raw;
  end

  // Move the cursor and clamp; the low edge is tested first.
  always_comb begin
    sum_x = $signed(CW'(col)) + CW'(pkt.dx);
    sum_y = $signed(CW'(row)) - CW'(pkt.dy);
    if (sum_x < 0)          new_x = '0;
    else if (sum_x > lim_x) new_x = lim_x;
    else                    new_x = sum_x;
    if (sum_y < 0)          new_y = '0;
    else if (sum_y > lim_y) new_y = lim_y;
    else                    new_y = sum_y;
  end

  // State after this byte; only a completed packet changes it.
  always_comb begin
    col_next   = col;
    row_next   = row;
    left_next  = left_state;
    right_next = right_state;
    if (pkt.done) begin
      col_next   = new_x[COORD_BITS-1:0];
      row_next   = new_y[COORD_BITS-1:0];
      left_next  = pkt.left;
      right_next = pkt.right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= COORD_BITS'(CURSOR_HOME);
      row         <= COORD_BITS'(CURSOR_HOME);
      left_state  <= 1'b0;
      right_state <= 1'b0;
    end else if (accept) begin
      col         <= col_next;
      row         <= row_next;
      left_state  <= left_next;
      right_state <= right_next;
    end
  end

endmodule

// ===== hdl/ps2_mouse_cursor_tracker.sv =====
// A result beat is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register drains while the
// next byte is taken, so the only limit is the downstream stall.
// Reset (rst, synchronous): cursor at column 50 row 50, buttons released,
// framer waiting for a header, registers at 1024x768 screen and 16x16 pointer.
module ps2_mouse_cursor_tracker
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SCREEN_BITS-1:0]  cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_BITS-1:0]    data_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [POS_BITS-1:0]     pos_x,
  output logic [POS_BITS-1:0]     pos_y,
  output logic                    left_pressed,
  output logic                    right_pressed,
  output logic                    packet_done,
  output logic                    byte_dropped
);

  cfg_t                  cfg;
  pos_t                  pos;
  pkt_t                  pkt;
  logic                  in_acc;
  logic [COORD_BITS-1:0] col_next;
  logic [COORD_BITS-1:0] row_next;
  logic                  left_next;
  logic                  right_next;

  // A byte is taken unless a result beat is held by the consumer.
  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  ps2mct_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ps2mct_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_acc),
    .data_byte (data_byte),
    .pos       (pos),
    .pkt       (pkt)
  );

  ps2mct_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_acc),
    .pkt        (pkt),
    .cfg        (cfg),
    .col_next   (col_next),
    .row_next   (row_next),
    .left_next  (left_next),
    .right_next (right_next)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register, loaded with each accepted byte's result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_x         <= POS_BITS'(col_next);
      pos_y         <= POS_BITS'(row_next);
      left_pressed  <= left_next;
      right_pressed <= right_next;
      packet_done   <= pkt.done;
      byte_dropped  <= pkt.dropped;
    end
  end

  // A beat never reports a finished packet and a dropped byte together.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(packet_done && byte_dropped))
    else $error("packet_done and byte_dropped both set");

  // A header byte without the sync bit is reported as dropped.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && pos == POS_HEADER && !data_byte[HDR_SYNC]) |=> (out_valid && byte_dropped))
    else $error("unsynced header byte not dropped");

  // Cursor row only moves when a packet completes: it matches the last beat's row.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && !pkt.done && out_valid) |-> (POS_BITS'(row_next) == pos_y))
    else $error("cursor row moved without a packet");

endmodule

// ===== sim/ps2mct_cursor_checker.sv =====
// Watches the register, byte and result channels of the cursor tracker,
// predicts each result beat from the accepted bytes and compares it.
module ps2mct_cursor_checker
  import ps2mct_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SCREEN_BITS-1:0]  cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [BYTE_BITS-1:0]    data_byte,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [POS_BITS-1:0]     pos_x,
  input  logic [POS_BITS-1:0]     pos_y,
  input  logic                    left_pressed,
  input  logic                    right_pressed,
  input  logic                    packet_done,
  input  logic                    byte_dropped,
  output int                      fail_count,
  output int                      pending,
  output int                      packet_count,
  output int                      drop_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
    logic                left;
    logic                right;
    logic                done;
    logic                dropped;
  } cursor_report_t;

  // Results predicted for accepted bytes, oldest first.
  cursor_report_t reports_due[$];

  // Predicted register file and framer/cursor state.
  cfg_t                 regs;
  pos_t                 frame_pos;
  logic [BYTE_BITS-1:0] hdr_byte;
  logic [BYTE_BITS-1:0] x_byte;
  int                   col;
  int                   row;
  logic                 left_st;
  logic                 right_st;

  // A clamp limit below zero pins the cursor at 0; above the coordinate range it saturates.
  function automatic int screen_limit(int span);
    if (span < 0) return 0;
    if (span > COORD_MAX) return COORD_MAX;
    return span;
  endfunction

  // The low clamp is tested before the high one.
  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Nine-bit delta from a delta byte and its sign bit in the header.
  function automatic int sign_delta(logic [BYTE_BITS-1:0] low, logic neg);
    return neg ? int'(low) - 256 : int'(low);
  endfunction

  // Advances the framer by one byte and returns the result beat it causes.
  function automatic cursor_report_t track_byte(logic [BYTE_BITS-1:0] b);
    cursor_report_t r;
    int dx;
    int dy;
    r.done = 1'b0;
    r.dropped = 1'b0;
    case (frame_pos)
      POS_DX: begin
        x_byte = b;
        frame_pos = POS_DY;
      end
      POS_DY: begin
        dx = sign_delta(x_byte, hdr_byte[HDR_XSIGN]);
        dy = sign_delta(b, hdr_byte[HDR_YSIGN]);
        col = clamp_to(col + dx,
                       screen_limit(int'(regs.screen_width) - int'(regs.pointer_width)));
        // Screen rows grow downward, so a positive Y delta moves the cursor up.
        row = clamp_to(row - dy,
                       screen_limit(int'(regs.screen_height) - int'(regs.pointer_height) - 1));
        left_st = hdr_byte[HDR_LEFT];
        right_st = hdr_byte[HDR_RIGHT];
        frame_pos = POS_HEADER;
        r.done = 1'b1;
      end
      default: begin
        // The unused position code behaves like waiting for a header.
        if (b[HDR_SYNC]) begin
          hdr_byte = b;
          frame_pos = POS_DX;
        end else begin
          frame_pos = POS_HEADER;
          r.dropped = 1'b1;
        end
      end
    endcase
    r.x = POS_BITS'(col);
    r.y = POS_BITS'(row);
    r.left = left_st;
    r.right = right_st;
    return r;
  endfunction

  function automatic bit field_differs(string name, logic [15:0] want, logic [15:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    cursor_report_t seen;
    cursor_report_t want;
    bit             bad;
    if (rst) begin
      regs = '{SCREEN_W_RST, SCREEN_H_RST, PTR_W_RST, PTR_H_RST};
      frame_pos = POS_HEADER;
      hdr_byte = '0;
      x_byte = '0;
      col = CURSOR_HOME;
      row = CURSOR_HOME;
      left_st = 1'b0;
      right_st = 1'b0;
      reports_due.delete();
    end else begin
      // Result beat: compare against the oldest prediction.
      if (out_valid && !out_stall) begin
        seen = '{pos_x, pos_y, left_pressed, right_pressed, packet_done, byte_dropped};
        if (reports_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, got x=%0d y=%0d",
                   $time, pos_x, pos_y);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          bad = field_differs("pos_x", want.x, seen.x)
              | field_differs("pos_y", want.y, seen.y)
              | field_differs("left_pressed", want.left, seen.left)
              | field_differs("right_pressed", want.right, seen.right)
              | field_differs("packet_done", want.done, seen.done)
              | field_differs("byte_dropped", want.dropped, seen.dropped);
          if (bad) fail_count++;
        end
      end

      // Register beat: values are masked to the register width.
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SCREEN_W: regs.screen_width = cfg_data;
          REG_SCREEN_H: regs.screen_height = cfg_data;
          REG_PTR_W:    regs.pointer_width = cfg_data[PTR_BITS-1:0];
          REG_PTR_H:    regs.pointer_height = cfg_data[PTR_BITS-1:0];
          default: ;
        endcase
      end

      // Byte beat: predict its result.
      if (in_valid && !in_stall) begin
        want = track_byte(data_byte);
        if (want.done) packet_count++;
        if (want.dropped) drop_count++;
        reports_due.push_back(want);
      end
    end
    pending = reports_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Drives mouse bytes and register writes into the cursor tracker, with random
// gaps and stalls, and reports the verdict from the checker's failure count.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ps2mct_pkg::*;

  localparam int COORD_BITS     = 12;
  localparam int HALF_PERIOD    = 6;
  localparam int HOLD_CYCLES    = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 10;

  typedef enum {DRIFT_NONE, DRIFT_DOWN_RIGHT, DRIFT_UP_LEFT} drift_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  reg_idx_t                cfg_index;
  logic [SCREEN_BITS-1:0]  cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [BYTE_BITS-1:0]    data_byte;
  logic                    out_valid;
  logic                    out_stall;
  logic [POS_BITS-1:0]     pos_x;
  logic [POS_BITS-1:0]     pos_y;
  logic                    left_pressed;
  logic                    right_pressed;
  logic                    packet_done;
  logic                    byte_dropped;

  int fail_count;
  int pending;
  int packet_count;
  int drop_count;
  int sent_bytes;
  int quiet_cycles;
  bit idle_on;
  bit hold_req;

  always #(HALF_PERIOD) clk = ~clk;

  ps2_mouse_cursor_tracker #(.COORD_BITS(COORD_BITS)) DUT (.*);

  ps2mct_cursor_checker #(.COORD_BITS(COORD_BITS)) cursor_check (.*);

  // Stop the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: a random stall before each beat while idle_on is set, plus one long hold on request.
  initial begin : result_sink
    int stall_left;
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) stall_left = idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // All stimulus tasks are entered at a falling edge and return at one.
  task automatic send_byte(logic [BYTE_BITS-1:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_packet(logic [BYTE_BITS-1:0] hdr, logic [BYTE_BITS-1:0] dx,
                             logic [BYTE_BITS-1:0] dy);
    send_byte(hdr);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Stop offering bytes and wait for every predicted result beat.
  task automatic wait_drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [SCREEN_BITS-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Pointer writes carry random upper bits to exercise the width masking.
  task automatic write_setting(cfg_t s);
    write_reg(REG_SCREEN_W, s.screen_width);
    write_reg(REG_SCREEN_H, s.screen_height);
    write_reg(REG_PTR_W, {5'($urandom_range(0, 31)), s.pointer_width});
    write_reg(REG_PTR_H, {5'($urandom_range(0, 31)), s.pointer_height});
  endtask

  initial begin : stimulus
    cfg_t                 plan [8];
    drift_t               plan_drift [8];
    cfg_t                 s;
    drift_t               drift;
    int                   budget;
    int                   start;
    logic [BYTE_BITS-1:0] hdr;
    logic [BYTE_BITS-1:0] dx;
    logic [BYTE_BITS-1:0] dy;

    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SCREEN_W;
    cfg_data = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;

    // Register settings per phase, from tiny and all-zero screens to the 13-bit maximum.
    plan[0] = '{13'd64,   13'd48,   8'd8,   8'd8};
    plan[1] = '{13'd0,    13'd0,    8'd0,   8'd0};
    plan[2] = '{13'd8191, 13'd8191, 8'd255, 8'd255};
    plan[3] = '{13'd8191, 13'd8191, 8'd0,   8'd0};
    plan[4] = '{13'd1,    13'd1,    8'd255, 8'd255};
    plan[5] = '{13'd4096, 13'd4096, 8'd0,   8'd0};
    plan[6] = '{13'd1024, 13'd768,  8'd16,  8'd16};
    plan[7] = '{13'd4096, 13'd1,    8'd0,   8'd0};
    plan_drift = '{DRIFT_NONE, DRIFT_NONE, DRIFT_DOWN_RIGHT, DRIFT_UP_LEFT,
                   DRIFT_NONE, DRIFT_DOWN_RIGHT, DRIFT_NONE, DRIFT_UP_LEFT};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed bytes at the reset setting: headers lacking the sync bit, zero and
    // extreme deltas of both signs, both button flags, then the right and bottom clamps.
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'hFF, 8'h00, 8'h00);
    send_packet(8'h0B, 8'hFF, 8'hFF);
    send_packet(8'h38, 8'h01, 8'hFF);
    repeat (4) send_packet(8'h29, 8'hFF, 8'h00);

    // Random phases, each at its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      if (p < 8) begin
        s = plan[p];
        drift = plan_drift[p];
      end else begin
        s.screen_width = SCREEN_BITS'($urandom_range(1, 4096));
        s.screen_height = SCREEN_BITS'($urandom_range(1, 4096));
        s.pointer_width = PTR_BITS'($urandom_range(0, 255));
        s.pointer_height = PTR_BITS'($urandom_range(0, 255));
        drift = drift_t'($urandom_range(0, 2));
      end
      write_setting(s);

      // Phases 1, 5 and 9 run back to back; phase 4 also does, against a long result hold so the block backs up.
      idle_on = (p % 4 != 1) && (p != 4);
      if (p == 4) hold_req = 1'b1;

      // Wide screens need more bytes to reach the far edges.
      budget = (s.screen_width > 2000) ? 110 : 40;
      start = sent_bytes;
      while (sent_bytes - start < budget) begin
        if ($urandom_range(0, 99) < 12) begin
          // Stray byte: breaks the framing or gets dropped as a bad header.
          send_byte(BYTE_BITS'($urandom));
        end else begin
          hdr = BYTE_BITS'($urandom);
          dx = BYTE_BITS'($urandom);
          dy = BYTE_BITS'($urandom);
          hdr[HDR_SYNC] = 1'b1;
          case (drift)
            DRIFT_DOWN_RIGHT: begin
              hdr[HDR_XSIGN] = 1'b0;
              dx[7] = 1'b1;
              hdr[HDR_YSIGN] = 1'b1;
              dy[7] = 1'b0;
            end
            DRIFT_UP_LEFT: begin
              hdr[HDR_XSIGN] = 1'b1;
              dx[7] = 1'b0;
              hdr[HDR_YSIGN] = 1'b0;
              dy[7] = 1'b1;
            end
            default: ;
          endcase
          send_packet(hdr, dx, dy);
        end
      end
    end

    wait_drain();
    repeat (10) @(negedge clk);

    $display("Ran %0d bytes over %0d register settings: %0d packets, %0d bad headers.",
             sent_bytes, PHASES + 1, packet_count, drop_count);
    $display("Settings spanned zero to maximum screen sizes, with a %0d-cycle result hold.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
